// ===== rtl/core/arbb_pkg.sv =====
`default_nettype none
package arbb_pkg;

	// Field widths of the cell and box transactions.
	localparam int COORD_W = 11;
	localparam int DENS_W  = 16;

	// Configuration register indexes (byte address is four times the index).
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_DENSITY_THRESHOLD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MARGIN            = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH        = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT       = 2'd3;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Reset values of the grid size registers.
	localparam logic [COORD_W-1:0] GRID_SIZE_RESET = 11'd1024;

	// Lowest interior coordinate.
	localparam logic [COORD_W-1:0] COORD_ONE = 11'd1;

	typedef struct packed {
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [DENS_W-1:0]  cell_density;
		logic               frame_last;
	} cell_t;

	typedef struct packed {
		logic [COORD_W-1:0] box_min_x;
		logic [COORD_W-1:0] box_max_x;
		logic [COORD_W-1:0] box_min_y;
		logic [COORD_W-1:0] box_max_y;
		logic               frame_empty;
	} box_t;

	typedef struct packed {
		logic [DENS_W-1:0]  density_threshold;
		logic [COORD_W-1:0] margin;
		logic [COORD_W-1:0] grid_width;
		logic [COORD_W-1:0] grid_height;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/arbb_ifs.sv =====
`default_nettype none
// Cell stream: one grid cell per transaction.
interface arbb_cell_if import arbb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;
	logic [DENS_W-1:0]  cell_density;
	logic               frame_last;

	modport source (output valid, output cell_x, output cell_y, output cell_density,
		output frame_last, input ready);
	modport sink (input valid, input cell_x, input cell_y, input cell_density,
		input frame_last, output ready);
endinterface

// Box stream: one new window per frame.
interface arbb_box_if import arbb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] box_min_x;
	logic [COORD_W-1:0] box_max_x;
	logic [COORD_W-1:0] box_min_y;
	logic [COORD_W-1:0] box_max_y;
	logic               frame_empty;

	modport source (output valid, output box_min_x, output box_max_x, output box_min_y,
		output box_max_y, output frame_empty, input ready);
	modport sink (input valid, input box_min_x, input box_max_x, input box_min_y,
		input box_max_y, input frame_empty, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/active_region_bounding_box_unit.sv =====
`default_nettype none
// Channel    Direction  Transaction
// grid_cell  in         one grid cell: cell_x, cell_y, cell_density, frame_last
// box        out        new window on the last cell: box bounds, frame_empty
// APB        in         register writes and reads, pready always high
//
// One cell is taken every cycle unless a last cell waits in the cell register.
// The cell register feeds the window/tracker logic, whose box lands in the result register.
// A last cell waits in the cell register while an earlier box is still not taken.
// Reset sets the window to the full grid, clears the trackers and loads register defaults.
module active_region_bounding_box_unit import arbb_pkg::*; #(
	parameter int MAX_GRID     = 1024,
	parameter int DENSITY_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	arbb_cell_if.sink                  grid_cell,
	arbb_box_if.source                 box,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t  cfg;
	cell_t cell_s1;
	logic  cell_valid_s1;
	box_t  box_res;
	box_t  box_q;
	logic  box_valid_q;
	logic  box_free, step, cell_take;

	arbb_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: a cell moves on unless it is a last cell facing a full result register.
	assign box_free        = !box_valid_q || box.ready;
	assign step            = cell_valid_s1 && (!cell_s1.frame_last || box_free);
	assign grid_cell.ready = !cell_valid_s1 || step;
	assign cell_take       = grid_cell.valid && grid_cell.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_s1 <= 1'b0;
		end else if (cell_take) begin
			cell_valid_s1 <= 1'b1;
		end else if (step) begin
			cell_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_take) begin
			cell_s1.cell_x       <= grid_cell.cell_x;
			cell_s1.cell_y       <= grid_cell.cell_y;
			cell_s1.cell_density <= grid_cell.cell_density;
			cell_s1.frame_last   <= grid_cell.frame_last;
		end
	end

	arbb_tracker #(
		.MAX_GRID     (MAX_GRID),
		.DENSITY_BITS (DENSITY_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.grid_cell (cell_s1),
		.cfg       (cfg),
		.result    (box_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q <= 1'b0;
		end else if (step && cell_s1.frame_last) begin
			box_valid_q <= 1'b1;
		end else if (box.ready) begin
			box_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && cell_s1.frame_last) begin
			box_q <= box_res;
		end
	end

	assign box.valid       = box_valid_q;
	assign box.box_min_x   = box_q.box_min_x;
	assign box.box_max_x   = box_q.box_max_x;
	assign box.box_min_y   = box_q.box_min_y;
	assign box.box_max_y   = box_q.box_max_y;
	assign box.frame_empty = box_q.frame_empty;

endmodule
`default_nettype wire

// ===== rtl/core/arbb_apb_regs.sv =====
`default_nettype none
module arbb_apb_regs import arbb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic                  wr_en;
	logic [REG_IDX_W-1:0]  reg_idx;
	cfg_t                  cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg     = cfg_q;

	// Register writes in the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.density_threshold <= '0;
			cfg_q.margin            <= '0;
			cfg_q.grid_width        <= GRID_SIZE_RESET;
			cfg_q.grid_height       <= GRID_SIZE_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DENSITY_THRESHOLD: cfg_q.density_threshold <= pwdata[DENS_W-1:0];
				REG_MARGIN:            cfg_q.margin            <= pwdata[COORD_W-1:0];
				REG_GRID_WIDTH:        cfg_q.grid_width        <= pwdata[COORD_W-1:0];
				REG_GRID_HEIGHT:       cfg_q.grid_height       <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero extended.
	always_comb begin
		unique case (reg_idx)
			REG_DENSITY_THRESHOLD: prdata = APB_DATA_W'(cfg_q.density_threshold);
			REG_MARGIN:            prdata = APB_DATA_W'(cfg_q.margin);
			REG_GRID_WIDTH:        prdata = APB_DATA_W'(cfg_q.grid_width);
			REG_GRID_HEIGHT:       prdata = APB_DATA_W'(cfg_q.grid_height);
			default:               prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/arbb_tracker.sv =====
`default_nettype none
module arbb_tracker import arbb_pkg::*; #(
	parameter int MAX_GRID     = 1024,
	parameter int DENSITY_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  cell_t      grid_cell,
	input  cfg_t       cfg,
	output box_t       result
);

	// Only the low DCMP bits (DENSITY_BITS, capped at DENS_W) of density and threshold take part.
	localparam int DCMP = (DENSITY_BITS < DENS_W) ? DENSITY_BITS : DENS_W;
	localparam logic [COORD_W-1:0] GRID_RST = COORD_W'(MAX_GRID % (1 << COORD_W));

	logic [COORD_W-1:0] win_min_x_q, win_max_x_q, win_min_y_q, win_max_y_q;
	logic [COORD_W-1:0] seen_min_x_q, seen_max_x_q, seen_min_y_q, seen_max_y_q;
	logic               any_seen_q;

	logic               in_window, hit;
	logic [COORD_W-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
	logic               n_any;
	logic [COORD_W:0]   hi_x, hi_y;
	box_t               box;

	// Window test and occupancy test for the current cell.
	always_comb begin
		in_window = (grid_cell.cell_x >= win_min_x_q) && (grid_cell.cell_x <= win_max_x_q) &&
			(grid_cell.cell_y >= win_min_y_q) && (grid_cell.cell_y <= win_max_y_q);
		hit = in_window &&
			(grid_cell.cell_density[DCMP-1:0] > cfg.density_threshold[DCMP-1:0]);
	end

	// Tracker update; the first counting cell loads all four bounds.
	always_comb begin
		n_min_x = seen_min_x_q;
		n_max_x = seen_max_x_q;
		n_min_y = seen_min_y_q;
		n_max_y = seen_max_y_q;
		n_any   = any_seen_q || hit;
		if (hit) begin
			if (!any_seen_q || grid_cell.cell_x < seen_min_x_q) n_min_x = grid_cell.cell_x;
			if (!any_seen_q || grid_cell.cell_x > seen_max_x_q) n_max_x = grid_cell.cell_x;
			if (!any_seen_q || grid_cell.cell_y < seen_min_y_q) n_min_y = grid_cell.cell_y;
			if (!any_seen_q || grid_cell.cell_y > seen_max_y_q) n_max_y = grid_cell.cell_y;
		end
	end

	// Widen by the margin and clamp: lower bound to 1, upper bound to the grid size; no counting cell gives the full grid.
	always_comb begin
		hi_x = {1'b0, n_max_x} + {1'b0, cfg.margin};
		hi_y = {1'b0, n_max_y} + {1'b0, cfg.margin};
		if (n_any) begin
			box.box_min_x = (cfg.margin >= n_min_x) ? COORD_ONE : n_min_x - cfg.margin;
			box.box_min_y = (cfg.margin >= n_min_y) ? COORD_ONE : n_min_y - cfg.margin;
			box.box_max_x = (hi_x > {1'b0, cfg.grid_width}) ? cfg.grid_width
				: hi_x[COORD_W-1:0];
			box.box_max_y = (hi_y > {1'b0, cfg.grid_height}) ? cfg.grid_height
				: hi_y[COORD_W-1:0];
			box.frame_empty = 1'b0;
		end else begin
			box.box_min_x   = COORD_ONE;
			box.box_max_x   = cfg.grid_width;
			box.box_min_y   = COORD_ONE;
			box.box_max_y   = cfg.grid_height;
			box.frame_empty = 1'b1;
		end
	end

	assign result = box;

	// Window and tracker state; the last cell stores the new window and clears the trackers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_x_q  <= COORD_ONE;
			win_max_x_q  <= GRID_RST;
			win_min_y_q  <= COORD_ONE;
			win_max_y_q  <= GRID_RST;
			seen_min_x_q <= GRID_RST;
			seen_max_x_q <= '0;
			seen_min_y_q <= GRID_RST;
			seen_max_y_q <= '0;
			any_seen_q   <= 1'b0;
		end else if (step) begin
			if (grid_cell.frame_last) begin
				win_min_x_q  <= box.box_min_x;
				win_max_x_q  <= box.box_max_x;
				win_min_y_q  <= box.box_min_y;
				win_max_y_q  <= box.box_max_y;
				seen_min_x_q <= GRID_RST;
				seen_max_x_q <= '0;
				seen_min_y_q <= GRID_RST;
				seen_max_y_q <= '0;
				any_seen_q   <= 1'b0;
			end else begin
				seen_min_x_q <= n_min_x;
				seen_max_x_q <= n_max_x;
				seen_min_y_q <= n_min_y;
				seen_max_y_q <= n_max_y;
				any_seen_q   <= n_any;
			end
		end
	end

endmodule
`default_nettype wire
